@@ src/bcs_pkg.sv @@
package bcs_pkg;

    // defaults for the top level parameters
    localparam int BLOCKS_PER_BUFFER_DEF = 8;
    localparam int RING_ENTRIES_DEF      = 8;

    // largest chunk a single dma launch may carry, before buffer rounding
    localparam int MAX_TRANSFER_BLOCKS = 65535;

    localparam int ADDR_W     = 32;
    localparam int LEN_W      = 16;
    localparam int FILL_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // request kinds carried on the input side band
    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_POLL  = 2'd1,
        REQ_DONE  = 2'd2,
        REQ_ERROR = 2'd3
    } t_req;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_BLOCK   = 2'd0,
        CFG_BLOCK_TOTAL   = 2'd1,
        CFG_DIRECTION     = 2'd2,
        CFG_CARD_CAPACITY = 2'd3
    } t_cfg_idx;

    // one input request
    typedef struct packed {
        t_req              req_type;
        logic              card_ready;
        logic [FILL_W-1:0] ring_fill;
    } t_item;

    // checked start parameters, settled after each configuration write
    typedef struct packed {
        logic              ok;
        logic              dir_write;
        logic [ADDR_W-1:0] first_block;
        logic [ADDR_W-1:0] total;
    } t_start_info;

    // one result
    typedef struct packed {
        logic              start_accepted;
        logic              issue_chunk;
        logic [ADDR_W-1:0] chunk_address;
        logic [LEN_W-1:0]  chunk_length;
        logic [2:0]        phase;
        logic              finished;
        logic              failed;
    } t_result;

endpackage

@@ src/bcs_cfg_calc.sv @@
module bcs_cfg_calc #(
    parameter int BLOCKS_PER_BUFFER = bcs_pkg::BLOCKS_PER_BUFFER_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  bcs_pkg::t_cfg_idx                 i_cfg_index,
    input  logic [bcs_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output logic                              o_busy,
    output bcs_pkg::t_start_info              o_start
);
    import bcs_pkg::*;

    // reciprocal for the round down to whole buffers
    localparam int          SHIFT    = 32 + $clog2(BLOCKS_PER_BUFFER);
    localparam int          RECIP_W  = 34;
    localparam int          PROD_W   = ADDR_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((64'd1 << SHIFT) / BLOCKS_PER_BUFFER);
    localparam logic [ADDR_W-1:0]  BPB    = ADDR_W'(BLOCKS_PER_BUFFER);
    localparam logic [1:0]         SETTLE = 2'd3;

    logic [ADDR_W-1:0] r_first_block;
    logic [ADDR_W-1:0] r_block_total;
    logic              r_direction;
    logic [ADDR_W-1:0] r_card_capacity;
    logic [1:0]        r_busy_cnt;

    logic [ADDR_W-1:0] r_a_total;
    logic [ADDR_W-1:0] r_a_first;
    logic              r_a_dir;
    logic              r_a_valid;

    logic [PROD_W-1:0] r_b_prod;
    logic [ADDR_W-1:0] r_b_total;
    logic [ADDR_W-1:0] r_b_first;
    logic              r_b_dir;
    logic              r_b_valid;

    t_start_info       r_start;

    logic [ADDR_W-1:0] w_avail;
    logic [ADDR_W-1:0] w_clamped;
    logic              w_valid;
    logic [ADDR_W-1:0] w_quot;
    logic [ADDR_W-1:0] w_rem_raw;
    logic [ADDR_W-1:0] w_rem;
    logic [ADDR_W-1:0] w_rounded;

    // configuration registers and settle counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_block   <= '0;
            r_block_total   <= '0;
            r_direction     <= 1'b0;
            r_card_capacity <= '0;
            r_busy_cnt      <= SETTLE;
        end else if (i_cfg_wr_en) begin
            r_busy_cnt <= SETTLE;
            case (i_cfg_index)
                CFG_FIRST_BLOCK:   r_first_block   <= i_cfg_wdata;
                CFG_BLOCK_TOTAL:   r_block_total   <= i_cfg_wdata;
                CFG_DIRECTION:     r_direction     <= i_cfg_wdata[0];
                CFG_CARD_CAPACITY: r_card_capacity <= i_cfg_wdata;
                default: ;
            endcase
        end else if (r_busy_cnt != 2'd0) begin
            r_busy_cnt <= r_busy_cnt - 2'd1;
        end
    end

    // stage a: clamp reads to the card
    always_comb begin
        w_avail   = r_card_capacity - r_first_block;
        w_clamped = r_block_total;
        if (!r_direction && (r_block_total > w_avail)) begin
            w_clamped = w_avail;
        end
        w_valid = (r_block_total != '0) &&
                  (r_direction || (r_first_block < r_card_capacity));
    end

    always_ff @(posedge i_clk) begin
        r_a_total <= w_clamped;
        r_a_first <= r_first_block;
        r_a_dir   <= r_direction;
        r_a_valid <= w_valid;
    end

    // stage b: reciprocal multiply
    always_ff @(posedge i_clk) begin
        r_b_prod  <= PROD_W'(r_a_total) * PROD_W'(RECIP);
        r_b_total <= r_a_total;
        r_b_first <= r_a_first;
        r_b_dir   <= r_a_dir;
        r_b_valid <= r_a_valid;
    end

    // stage c: remainder with one correction step, then the start check
    always_comb begin
        w_quot    = ADDR_W'(r_b_prod >> SHIFT);
        w_rem_raw = r_b_total - ADDR_W'(w_quot * BPB);
        w_rem     = (w_rem_raw >= BPB) ? (w_rem_raw - BPB) : w_rem_raw;
        w_rounded = r_b_total - w_rem;
    end

    always_ff @(posedge i_clk) begin
        r_start.ok          <= r_b_valid &&
                               (r_b_dir ? (w_rem == '0) : (w_rounded != '0));
        r_start.dir_write   <= r_b_dir;
        r_start.first_block <= r_b_first;
        r_start.total       <= w_rounded;
    end

    assign o_busy  = (r_busy_cnt != 2'd0);
    assign o_start = r_start;

endmodule

@@ src/bcs_core.sv @@
module bcs_core #(
    parameter int BLOCKS_PER_BUFFER = bcs_pkg::BLOCKS_PER_BUFFER_DEF,
    parameter int RING_ENTRIES      = bcs_pkg::RING_ENTRIES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  bcs_pkg::t_item       i_item,
    input  bcs_pkg::t_start_info i_start,
    output bcs_pkg::t_result     o_res
);
    import bcs_pkg::*;

    localparam logic [LEN_W-1:0] CHUNK_LIMIT =
        LEN_W'((MAX_TRANSFER_BLOCKS / BLOCKS_PER_BUFFER) * BLOCKS_PER_BUFFER);
    localparam int FREE_W = $clog2(RING_ENTRIES + 1);
    localparam int LIM_W  = FREE_W + $clog2(BLOCKS_PER_BUFFER + 1);

    localparam logic [2:0] PHC_IDLE  = 3'd0;
    localparam logic [2:0] PHC_START = 3'd1;
    localparam logic [2:0] PHC_WAIT  = 3'd2;
    localparam logic [2:0] PHC_DONE  = 3'd3;
    localparam logic [2:0] PHC_ERROR = 3'd4;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_START = 5'b00010,
        PH_WAIT  = 5'b00100,
        PH_DONE  = 5'b01000,
        PH_ERROR = 5'b10000
    } t_phase;

    typedef enum logic [1:0] {
        DIR_NONE  = 2'd0,
        DIR_READ  = 2'd1,
        DIR_WRITE = 2'd2
    } t_dir;

    t_phase            r_phase,  n_phase;
    logic [ADDR_W-1:0] r_next_address, n_next_address;
    logic [ADDR_W-1:0] r_blocks_left,  n_blocks_left;
    logic [LEN_W-1:0]  r_active_len,   n_active_len;
    t_dir              r_dir,     n_dir;
    logic              r_done_pend,  n_done_pend;
    logic              r_err_pend,   n_err_pend;
    logic              r_finished,   n_finished;
    logic              r_failed,     n_failed;

    logic [LEN_W-1:0]  w_chunk_base;
    logic [FREE_W-1:0] w_free;
    logic [LIM_W-1:0]  w_lim;
    logic [LEN_W-1:0]  w_chunk;
    logic              w_launch;
    t_result           w_res;

    // chunk size: remaining blocks, chunk limit, and ring space on reads
    always_comb begin
        w_chunk_base = (r_blocks_left > ADDR_W'(CHUNK_LIMIT)) ?
                       CHUNK_LIMIT : r_blocks_left[LEN_W-1:0];
        if (32'(i_item.ring_fill) >= 32'(RING_ENTRIES)) begin
            w_free = '0;
        end else begin
            w_free = FREE_W'(32'(RING_ENTRIES) - 32'(i_item.ring_fill));
        end
        w_lim    = LIM_W'(w_free) * LIM_W'(BLOCKS_PER_BUFFER);
        w_chunk  = w_chunk_base;
        w_launch = 1'b1;
        if (r_dir == DIR_READ) begin
            if (w_lim == '0) begin
                w_launch = 1'b0;
            end else if (32'(w_chunk_base) > 32'(w_lim)) begin
                w_chunk = LEN_W'(w_lim);
            end
        end
    end

    // next state and result for one request
    always_comb begin
        n_phase        = r_phase;
        n_next_address = r_next_address;
        n_blocks_left  = r_blocks_left;
        n_active_len   = r_active_len;
        n_dir          = r_dir;
        n_done_pend    = r_done_pend;
        n_err_pend     = r_err_pend;
        n_finished     = r_finished;
        n_failed       = r_failed;
        w_res          = '0;

        case (i_item.req_type)
            REQ_START: begin
                if (i_start.ok) begin
                    w_res.start_accepted = 1'b1;
                    n_next_address = i_start.first_block;
                    n_blocks_left  = i_start.total;
                    n_active_len   = '0;
                    n_dir          = i_start.dir_write ? DIR_WRITE : DIR_READ;
                    n_done_pend    = 1'b0;
                    n_err_pend     = 1'b0;
                    n_finished     = 1'b0;
                    n_failed       = 1'b0;
                    n_phase        = PH_START;
                end
            end
            REQ_DONE: begin
                n_done_pend = 1'b1;
            end
            REQ_ERROR: begin
                n_err_pend = 1'b1;
                n_failed   = 1'b1;
            end
            REQ_POLL: begin
                case (r_phase)
                    PH_START: begin
                        if (r_dir == DIR_NONE) begin
                            n_phase = PH_IDLE;
                        end else if (i_item.card_ready) begin
                            n_done_pend = 1'b0;
                            if (r_blocks_left == '0) begin
                                n_err_pend = 1'b1;
                                n_phase    = PH_ERROR;
                            end else if (w_launch && (w_chunk != '0)) begin
                                n_active_len        = w_chunk;
                                w_res.issue_chunk   = 1'b1;
                                w_res.chunk_address = r_next_address;
                                w_res.chunk_length  = w_chunk;
                                n_phase             = PH_WAIT;
                            end
                        end
                    end
                    PH_WAIT: begin
                        if (r_err_pend) begin
                            n_err_pend = 1'b0;
                            n_failed   = 1'b1;
                            n_dir      = DIR_NONE;
                            n_phase    = PH_ERROR;
                        end else if (r_done_pend) begin
                            n_done_pend    = 1'b0;
                            n_next_address = r_next_address + ADDR_W'(r_active_len);
                            n_blocks_left  = (ADDR_W'(r_active_len) > r_blocks_left) ?
                                             '0 : (r_blocks_left - ADDR_W'(r_active_len));
                            if (n_blocks_left != '0) begin
                                n_phase = PH_START;
                            end else begin
                                n_finished = 1'b1;
                                n_dir      = DIR_NONE;
                                n_phase    = PH_DONE;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase

        case (n_phase)
            PH_IDLE:  w_res.phase = PHC_IDLE;
            PH_START: w_res.phase = PHC_START;
            PH_WAIT:  w_res.phase = PHC_WAIT;
            PH_DONE:  w_res.phase = PHC_DONE;
            PH_ERROR: w_res.phase = PHC_ERROR;
            default:  w_res.phase = PHC_IDLE;
        endcase
        w_res.finished = n_finished;
        w_res.failed   = n_failed;
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_next_address <= '0;
            r_blocks_left  <= '0;
            r_active_len   <= '0;
            r_dir          <= DIR_NONE;
            r_done_pend    <= 1'b0;
            r_err_pend     <= 1'b0;
            r_finished     <= 1'b0;
            r_failed       <= 1'b0;
        end else if (i_valid) begin
            r_phase        <= n_phase;
            r_next_address <= n_next_address;
            r_blocks_left  <= n_blocks_left;
            r_active_len   <= n_active_len;
            r_dir          <= n_dir;
            r_done_pend    <= n_done_pend;
            r_err_pend     <= n_err_pend;
            r_finished     <= n_finished;
            r_failed       <= n_failed;
        end
    end

    assign o_res = w_res;

    // a launched chunk always moves to the wait phase with a nonzero length
    a_issue_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && w_res.issue_chunk) |->
            (w_res.phase == PHC_WAIT) && (w_res.chunk_length != '0))
        else $error("chunk launched without entering wait phase");

    // done phase only once every block is accounted for
    a_done_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE) |-> (r_blocks_left == '0) && r_finished)
        else $error("done phase with blocks left");

    // an accepted start restarts from a clean slate
    a_start_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && w_res.start_accepted) |=>
            (r_phase == PH_START) && !r_failed && !r_finished &&
            (r_blocks_left != '0))
        else $error("accepted start left stale state");

endmodule

@@ src/bcs_out_buf.sv @@
module bcs_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  bcs_pkg::t_result i_data,
    output logic             o_ready,
    output logic             o_valid,
    output bcs_pkg::t_result o_data,
    input  logic             i_ready
);
    import bcs_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    w_take;

    assign w_take = r_out_valid && i_ready;

    // control: output register plus one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_take) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_valid;
            end
        end else if (i_valid) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_valid) begin
                r_out <= i_data;
            end
        end else if (i_valid) begin
            if (r_out_valid) begin
                r_skid <= i_data;
            end else begin
                r_out <= i_data;
            end
        end
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // the skid entry is only used behind a held output
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty output register");

endmodule

@@ src/block_transfer_chunk_sequencer.sv @@
// Splits a multi-block card transfer into dma chunks. Each request on the
// input stream (start, poll, chunk done, error, selected by tuser) yields
// exactly one result, registered in the output buffer; one request can be
// taken every clock while the input is ready. Results pass through an output
// register with one skid entry, so a stalled output only blocks input once
// two results are waiting. The start check (read clamp to card capacity,
// round down to whole buffers by a reciprocal multiply) is computed from the
// configuration registers in a three-stage unit; after reset and after every
// configuration write the input stays not ready while that unit settles.
module block_transfer_chunk_sequencer #(
    parameter int BLOCKS_PER_BUFFER = bcs_pkg::BLOCKS_PER_BUFFER_DEF,
    parameter int RING_ENTRIES      = bcs_pkg::RING_ENTRIES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_wr_en,
    input  logic [bcs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bcs_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // request stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // card_ready, ring_fill[3:0]
    input  logic [1:0]                     s_axis_tuser,  // req_type[1:0]
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // start_accepted, chunk_address[31:0], chunk_length[15:0], phase[2:0],
    // finished, failed
    output logic [55:0]                    m_axis_tdata,
    output logic [0:0]                     m_axis_tuser   // issue_chunk
);
    import bcs_pkg::*;

    logic        w_cfg_busy;
    t_start_info w_start;
    t_item       w_item;
    t_result     w_res;
    t_result     w_out;
    logic        w_buf_ready;
    logic        w_accept;

    assign s_axis_tready = !w_cfg_busy && w_buf_ready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // unpack the request
    assign w_item.req_type   = t_req'(s_axis_tuser);
    assign w_item.card_ready = s_axis_tdata[0];
    assign w_item.ring_fill  = s_axis_tdata[4:1];

    bcs_cfg_calc #(
        .BLOCKS_PER_BUFFER (BLOCKS_PER_BUFFER)
    ) u_cfg_calc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (t_cfg_idx'(i_cfg_index)),
        .i_cfg_wdata (i_cfg_wdata),
        .o_busy      (w_cfg_busy),
        .o_start     (w_start)
    );

    bcs_core #(
        .BLOCKS_PER_BUFFER (BLOCKS_PER_BUFFER),
        .RING_ENTRIES      (RING_ENTRIES)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_item  (w_item),
        .i_start (w_start),
        .o_res   (w_res)
    );

    bcs_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_data  (w_res),
        .o_ready (w_buf_ready),
        .o_valid (m_axis_tvalid),
        .o_data  (w_out),
        .i_ready (m_axis_tready)
    );

    // pack the result
    assign m_axis_tdata = {2'b00, w_out.failed, w_out.finished, w_out.phase,
                           w_out.chunk_length, w_out.chunk_address,
                           w_out.start_accepted};
    assign m_axis_tuser = w_out.issue_chunk;

endmodule
